### hdl/sfd_pkg.sv
// Shared types, constants and the record length table for the sensor frame deframer.
// Used by sfd_parser, sfd_result_fifo and sensor_frame_deframer.
package sfd_pkg;

	localparam logic [7:0] MARKER_BYTE = 8'hFF;

	// Result kinds.
	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic [4:0] byte_index;
		logic [7:0] record_type;
		logic       frame_last;
		logic       checksum_ok;
		logic       ack_request;
	} sfd_result_t;

	// Up to two results are produced per stream byte.
	typedef struct packed {
		logic [1:0]  cnt;
		sfd_result_t res0;
		sfd_result_t res1;
	} sfd_push_t;

	// Frame length for each known record type; zero marks an unknown type.
	function automatic logic [4:0] frame_length_of(input logic [7:0] rec_type);
		logic [4:0] len;
		begin
			case (rec_type)
				8'h41: len = 5'd17;
				8'h42: len = 5'd12;
				8'h44: len = 5'd7;
				8'h46: len = 5'd8;
				8'h47: len = 5'd6;
				8'h48: len = 5'd11;
				8'h60: len = 5'd12;
				default: len = 5'd0;
			endcase
			return len;
		end
	endfunction

endpackage

### hdl/sfd_parser.sv
// Input register and frame parsing state machine of the sensor frame deframer.
// Depends on sfd_pkg for the result types and the length table.
module sfd_parser import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic [7:0] rx_byte,
	output logic       rx_stall,
	input  logic       room,
	output sfd_push_t  push
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_SKIP = 2'd1;
	localparam logic [1:0] PH_TYPE = 2'd2;
	localparam logic [1:0] PH_BODY = 2'd3;

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic [1:0]  phase_q;
	logic [7:0]  header_byte_q;
	logic [7:0]  current_type_q;
	logic [4:0]  frame_length_q;
	logic [4:0]  byte_count_q;
	logic [11:0] running_sum_q;
	logic [7:0]  trailer_low_q;

	logic        advance;
	logic [4:0]  type_len;
	logic [5:0]  idx_plus1;
	logic [5:0]  idx_plus2;
	logic        body_last;
	logic        sum_match;

	assign advance  = in_valid_s1 & room;
	assign rx_stall = in_valid_s1 & ~room;

	assign type_len  = frame_length_of(in_byte_s1);
	assign idx_plus1 = {1'b0, byte_count_q} + 6'd1;
	assign idx_plus2 = {1'b0, byte_count_q} + 6'd2;
	assign body_last = idx_plus1 >= {1'b0, frame_length_q};
	assign sum_match = {4'd0, running_sum_q} == {in_byte_s1, trailer_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			in_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			in_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			header_byte_q  <= '0;
			current_type_q <= '0;
			frame_length_q <= '0;
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			trailer_low_q  <= '0;
		end else if (advance) begin
			case (phase_q)
				PH_HUNT: begin
					if (in_byte_s1 == MARKER_BYTE) begin
						phase_q <= PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (in_byte_s1 != MARKER_BYTE) begin
						header_byte_q <= in_byte_s1;
						phase_q       <= PH_TYPE;
					end
				end
				PH_TYPE: begin
					current_type_q <= in_byte_s1;
					if (type_len == 5'd0) begin
						phase_q <= PH_HUNT;
					end else begin
						frame_length_q <= type_len;
						byte_count_q   <= 5'd2;
						running_sum_q  <= {4'd0, header_byte_q} + {4'd0, in_byte_s1};
						phase_q        <= PH_BODY;
					end
				end
				default: begin
					if (body_last) begin
						phase_q <= PH_HUNT;
					end else begin
						// The second to last byte is the low half of the trailer.
						if (idx_plus2 == {1'b0, frame_length_q}) begin
							trailer_low_q <= in_byte_s1;
						end else begin
							running_sum_q <= running_sum_q + {4'd0, in_byte_s1};
						end
						byte_count_q <= idx_plus1[4:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		push.cnt  = 2'd0;
		push.res0 = '0;
		push.res1 = '0;
		if (advance) begin
			case (phase_q)
				PH_TYPE: begin
					if (type_len == 5'd0) begin
						push.cnt              = 2'd1;
						push.res0.kind        = KIND_REJECT;
						push.res0.out_byte    = in_byte_s1;
						push.res0.byte_index  = 5'd1;
						push.res0.record_type = in_byte_s1;
						push.res0.frame_last  = 1'b1;
						push.res0.ack_request = 1'b1;
					end else begin
						push.cnt              = 2'd2;
						push.res0.kind        = KIND_FRAME;
						push.res0.out_byte    = header_byte_q;
						push.res0.byte_index  = 5'd0;
						push.res0.record_type = in_byte_s1;
						push.res1.kind        = KIND_FRAME;
						push.res1.out_byte    = in_byte_s1;
						push.res1.byte_index  = 5'd1;
						push.res1.record_type = in_byte_s1;
					end
				end
				PH_BODY: begin
					push.cnt              = 2'd1;
					push.res0.kind        = KIND_FRAME;
					push.res0.out_byte    = in_byte_s1;
					push.res0.byte_index  = byte_count_q;
					push.res0.record_type = current_type_q;
					push.res0.frame_last  = body_last;
					push.res0.checksum_ok = body_last & sum_match;
					push.res0.ack_request = body_last;
				end
				default: begin
					push.cnt = 2'd0;
				end
			endcase
		end
	end

endmodule

### hdl/sfd_result_fifo.sv
// Small result queue that takes up to two results per cycle and delivers one per cycle while res_stall is low.
// Depends on sfd_pkg for the result types and queue geometry.
module sfd_result_fifo import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sfd_push_t   push,
	output logic        room,
	output logic        res_valid,
	input  logic        res_stall,
	output sfd_result_t res
);

	sfd_result_t           mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_ptr_next;

	assign res_valid   = count_q != '0;
	assign pop         = res_valid & ~res_stall;
	assign res         = mem[rd_ptr_q];
	assign room        = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign wr_ptr_next = wr_ptr_q + FIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_next] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
		end
	end

endmodule

### hdl/sensor_frame_deframer.sv
// Sensor frame deframer: cuts marked, length-typed frames out of a byte stream.
// Instantiates sfd_parser and sfd_result_fifo; depends on sfd_pkg.
//
// Usage:
//   Input channel rx_valid/rx_stall/rx_byte carries one stream byte per
//   transaction. Output channel res_valid/res_stall carries one result per
//   transaction in the fields kind, out_byte, byte_index, record_type,
//   frame_last, checksum_ok and ack_request.
//   A byte is registered at acceptance and parsed from that register; its
//   results are written into a four-entry result queue and offered on the
//   outputs from there. One byte can be accepted every cycle while rx_stall
//   is low. The header byte yields no result, a known type byte two (header
//   and type), an unknown one a reject, and each later frame byte one, so
//   with res_stall low the queue drains at one result per cycle and a
//   sustained rate of one byte per cycle holds. When the receiver stalls,
//   the queue fills; once it holds more than two results the parse register
//   holds its byte and rx_stall rises until space returns. Results stay
//   stable while res_stall is high.
//   Reset empties the queue and the input register and returns the parser to
//   hunting for a marker byte.
module sensor_frame_deframer import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] out_byte,
	output logic [4:0] byte_index,
	output logic [7:0] record_type,
	output logic       frame_last,
	output logic       checksum_ok,
	output logic       ack_request
);

	sfd_push_t   push;
	sfd_result_t res;
	logic        room;

	sfd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.rx_stall (rx_stall),
		.room     (room),
		.push     (push)
	);

	sfd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign kind        = res.kind;
	assign out_byte    = res.out_byte;
	assign byte_index  = res.byte_index;
	assign record_type = res.record_type;
	assign frame_last  = res.frame_last;
	assign checksum_ok = res.checksum_ok;
	assign ack_request = res.ack_request;

endmodule

### dv/tb_sensor_frame_deframer.sv
// Self-checking testbench for sensor_frame_deframer: marker hunt, typed frames, checksums.
// Depends on sfd_pkg for the result layout and the kind codes.
module tb_sensor_frame_deframer;
	import sfd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_SLACK  = 8;
	localparam int STREAM_BYTES = 500;

	// Known record types, named after their frame length.
	localparam logic [7:0] REC_LEN17  = 8'h41;
	localparam logic [7:0] REC_LEN12A = 8'h42;
	localparam logic [7:0] REC_LEN7   = 8'h44;
	localparam logic [7:0] REC_LEN8   = 8'h46;
	localparam logic [7:0] REC_LEN6   = 8'h47;
	localparam logic [7:0] REC_LEN11  = 8'h48;
	localparam logic [7:0] REC_LEN12B = 8'h60;
	localparam logic [7:0] KNOWN_TYPES [7] = '{REC_LEN17, REC_LEN12A, REC_LEN7, REC_LEN8,
		REC_LEN6, REC_LEN11, REC_LEN12B};

	typedef enum logic [1:0] {HUNT, SKIP_MARKERS, AWAIT_TYPE, IN_BODY} parse_phase_t;
	typedef enum int {BODY_RANDOM, BODY_ZERO, BODY_ONES} body_fill_t;
	typedef enum int {TRL_GOOD, TRL_WRONG, TRL_OVER} trailer_kind_t;

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       res_valid;
	logic       res_stall;
	logic       kind;
	logic [7:0] out_byte;
	logic [4:0] byte_index;
	logic [7:0] record_type;
	logic       frame_last;
	logic       checksum_ok;
	logic       ack_request;

	sensor_frame_deframer dut (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.kind(kind), .out_byte(out_byte), .byte_index(byte_index),
		.record_type(record_type), .frame_last(frame_last),
		.checksum_ok(checksum_ok), .ack_request(ack_request)
	);

	// Predictor state, mirroring the parser.
	parse_phase_t parse_phase;
	logic [7:0]   hdr_byte;
	logic [7:0]   cur_type;
	logic [4:0]   cur_length;
	logic [4:0]   pos_in_frame;
	logic [11:0]  frame_sum;
	logic [7:0]   trailer_lo;

	sfd_result_t pending_results[$];
	int          mismatch_count = 0;
	int          results_seen = 0;
	int          bytes_sent = 0;
	int          cycle_count = 0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          sink_hold_len = 0;
	bit          rx_valid_drv = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [4:0] record_length(input logic [7:0] rtype);
		case (rtype)
			REC_LEN17: return 5'd17;
			REC_LEN12A, REC_LEN12B: return 5'd12;
			REC_LEN7: return 5'd7;
			REC_LEN8: return 5'd8;
			REC_LEN6: return 5'd6;
			REC_LEN11: return 5'd11;
			default: return 5'd0;
		endcase
	endfunction

	task automatic queue_result(input logic k, input logic [7:0] b, input logic [4:0] idx,
			input logic [7:0] rtype, input logic last, input logic ok, input logic ack);
		sfd_result_t r;
		r.kind = k;
		r.out_byte = b;
		r.byte_index = idx;
		r.record_type = rtype;
		r.frame_last = last;
		r.checksum_ok = ok;
		r.ack_request = ack;
		pending_results.push_back(r);
	endtask

	// Advances the parser model by one accepted stream byte.
	task automatic predict_deframe(input logic [7:0] b);
		logic [4:0]  len;
		logic [15:0] trailer;
		case (parse_phase)
			HUNT: begin
				if (b == MARKER_BYTE)
					parse_phase = SKIP_MARKERS;
			end
			SKIP_MARKERS: begin
				if (b != MARKER_BYTE) begin
					hdr_byte = b;
					parse_phase = AWAIT_TYPE;
				end
			end
			AWAIT_TYPE: begin
				len = record_length(b);
				cur_type = b;
				if (len == 0) begin
					queue_result(KIND_REJECT, b, 5'd1, b, 1'b1, 1'b0, 1'b1);
					parse_phase = HUNT;
				end else begin
					cur_length = len;
					pos_in_frame = 5'd2;
					frame_sum = 12'(hdr_byte) + 12'(b);
					queue_result(KIND_FRAME, hdr_byte, 5'd0, b, 1'b0, 1'b0, 1'b0);
					queue_result(KIND_FRAME, b, 5'd1, b, 1'b0, 1'b0, 1'b0);
					parse_phase = IN_BODY;
				end
			end
			default: begin
				if (pos_in_frame + 5'd1 >= cur_length) begin
					trailer = {b, trailer_lo};
					queue_result(KIND_FRAME, b, pos_in_frame, cur_type, 1'b1,
						trailer == {4'h0, frame_sum}, 1'b1);
					parse_phase = HUNT;
				end else begin
					// The first trailer byte is held, not summed.
					if (pos_in_frame + 5'd2 == cur_length)
						trailer_lo = b;
					else
						frame_sum = frame_sum + 12'(b);
					queue_result(KIND_FRAME, b, pos_in_frame, cur_type, 1'b0, 1'b0, 1'b0);
					pos_in_frame = pos_in_frame + 5'd1;
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("%0t: mismatch on %s in result %0d: got 0x%0h, expected 0x%0h",
			$realtime, field, results_seen, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		sfd_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, out_byte", out_byte, 0);
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", kind, want.kind);
				if (out_byte !== want.out_byte)
					report_mismatch("out_byte", out_byte, want.out_byte);
				if (byte_index !== want.byte_index)
					report_mismatch("byte_index", byte_index, want.byte_index);
				if (record_type !== want.record_type)
					report_mismatch("record_type", record_type, want.record_type);
				if (frame_last !== want.frame_last)
					report_mismatch("frame_last", frame_last, want.frame_last);
				if (checksum_ok !== want.checksum_ok)
					report_mismatch("checksum_ok", checksum_ok, want.checksum_ok);
				if (ack_request !== want.ack_request)
					report_mismatch("ack_request", ack_request, want.ack_request);
			end
			results_seen++;
		end
	end

	// Result receiver: random stall bursts, or one long hold when a test asks for it.
	initial begin : result_sink
		int burst;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_len > 0) begin
				res_stall <= 1'b1;
				repeat (sink_hold_len) @(posedge clk);
				sink_hold_len = 0;
				res_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < sink_stall_pct) begin
				burst = $urandom_range(1, 19);
				res_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic quiet_input();
		if (rx_valid_drv) begin
			rx_valid <= 1'b0;
			rx_valid_drv = 0;
		end
	endtask

	// Offers one stream byte, waits for its transaction, then maybe idles a while.
	task automatic send_byte(input logic [7:0] b);
		rx_valid <= 1'b1;
		rx_byte <= b;
		rx_valid_drv = 1;
		do
			@(posedge clk);
		while (rx_stall);
		predict_deframe(b);
		bytes_sent++;
		if ($urandom_range(0, 99) < src_idle_pct) begin
			quiet_input();
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Sender pause: nothing offered until every expected result has come back.
	task automatic wait_drained();
		quiet_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic send_frame(input int markers, input logic [7:0] hdr, input logic [7:0] rtype,
			input body_fill_t fill, input trailer_kind_t trl);
		logic [4:0]  len;
		logic [15:0] sum;
		logic [15:0] trailer;
		logic [7:0]  b;
		int          i;
		len = record_length(rtype);
		repeat (markers) send_byte(MARKER_BYTE);
		send_byte(hdr);
		send_byte(rtype);
		if (len != 0) begin
			sum = 16'(hdr) + 16'(rtype);
			for (i = 2; i < len - 2; i++) begin
				case (fill)
					BODY_ZERO: b = 8'h00;
					BODY_ONES: b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				sum = sum + 16'(b);
				send_byte(b);
			end
			case (trl)
				TRL_GOOD: trailer = sum;
				TRL_OVER: trailer = {sum[15:8] | 8'h10, sum[7:0]};
				default: begin
					do
						trailer = 16'($urandom);
					while (trailer == sum);
				end
			endcase
			send_byte(trailer[7:0]);
			send_byte(trailer[15:8]);
		end
	endtask

	task automatic send_random_frame();
		trailer_kind_t trl;
		if ($urandom_range(0, 3) != 0)
			trl = TRL_GOOD;
		else
			trl = $urandom_range(0, 1) ? TRL_WRONG : TRL_OVER;
		send_frame($urandom_range(1, 3), 8'($urandom_range(0, 254)),
			KNOWN_TYPES[$urandom_range(0, 6)], BODY_RANDOM, trl);
	endtask

	task automatic test_hunt_discard();
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'hFE);
		wait_drained();
	endtask

	task automatic test_directed_frames();
		// Repeated markers before the header, a body of all ones and a matching sum.
		send_frame(3, 8'h00, REC_LEN6, BODY_ONES, TRL_GOOD);
		// Largest header, empty body bytes, trailer above the 12-bit sum range.
		send_frame(1, 8'hFE, REC_LEN7, BODY_ZERO, TRL_OVER);
		wait_drained();
	endtask

	task automatic test_unknown_types();
		send_frame(1, 8'h5A, 8'h00, BODY_RANDOM, TRL_GOOD);
		// A marker in the type position is rejected, not skipped.
		send_frame(2, 8'hA5, MARKER_BYTE, BODY_RANDOM, TRL_GOOD);
		wait_drained();
	endtask

	task automatic test_every_type();
		int t;
		src_idle_pct = 20;
		sink_stall_pct = 10;
		for (t = 0; t < 7; t++)
			send_frame(1, 8'($urandom_range(0, 254)), KNOWN_TYPES[t], BODY_RANDOM, TRL_GOOD);
		send_frame(1, 8'($urandom_range(0, 254)), REC_LEN17, BODY_ONES, TRL_GOOD);
		wait_drained();
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold_len = 120;
		@(posedge clk);
		send_frame(1, 8'($urandom_range(0, 254)), REC_LEN17, BODY_RANDOM, TRL_GOOD);
		send_frame(1, 8'($urandom_range(0, 254)), REC_LEN11, BODY_RANDOM, TRL_WRONG);
		wait_drained();
	endtask

	task automatic test_random_stream();
		int pick;
		int n;
		int frames = 0;
		logic [7:0] rtype;
		while (bytes_sent < STREAM_BYTES) begin
			if (frames % 5 == 0) begin
				n = $urandom_range(0, 2);
				src_idle_pct = (n == 0) ? 0 : (n == 1) ? 5 : 25;
				n = $urandom_range(0, 2);
				sink_stall_pct = (n == 0) ? 0 : (n == 1) ? 8 : 25;
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				send_random_frame();
			end else if (pick < 82) begin
				do
					rtype = 8'($urandom);
				while (record_length(rtype) != 0);
				send_frame($urandom_range(1, 2), 8'($urandom_range(0, 254)), rtype,
					BODY_RANDOM, TRL_GOOD);
			end else if (pick < 92) begin
				// Line noise, which may itself open a frame.
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(0, 3) == 0 ? MARKER_BYTE : 8'($urandom));
			end else begin
				// Broken start: marker and header, then any byte as the type.
				send_byte(MARKER_BYTE);
				send_byte(8'($urandom_range(0, 254)));
				send_byte(8'($urandom));
			end
			frames++;
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_full_rate();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (4) send_random_frame();
		wait_drained();
	endtask

	initial begin : main
		parse_phase = HUNT;
		hdr_byte = '0;
		cur_type = '0;
		cur_length = '0;
		pos_in_frame = '0;
		frame_sum = '0;
		trailer_lo = '0;
		arst_n <= 1'b0;
		rx_valid <= 1'b0;
		rx_byte <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hunt_discard();
		test_directed_frames();
		test_unknown_types();
		test_every_type();
		test_backpressure();
		test_random_stream();
		test_full_rate();

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
